>>> hdl/mmh_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mmh_pkg: shared types and constants for the min-max heap queue
// Holds the command and status codes, the default capacity, the
// sequencer state type and the min or max comparison function.
// ---------------------------------------------------------------------------
package mmh_pkg;

  localparam int unsigned DefCapacity = 1024;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_DELMIN = 3'd1,
    CMD_DELMAX = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_PEEK   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INS_RP,      // read the parent of the new leaf
    S_INS_CMP,     // compare with the parent
    S_BUB_RG,      // read the grandparent
    S_BUB_CMP,     // compare with the grandparent
    S_DEL_R1,      // node 1 arrives while node 2 is read, for delete max
    S_DEL_PICK,
    S_DEL_LAST,    // read the last leaf and move it up
    S_TR_START,    // start a trickle-down level
    S_TR_RD,       // read one candidate
    S_TR_CMP,      // fold it into the running best
    S_TR_RESOLVE,
    S_TR_RP,       // read the parent of a grandchild
    S_TR_PCMP,
    S_PK_R0,       // read the root and its children for the result
    S_PK_R1,
    S_PK_R2,
    S_PK_END,
    S_OUT
  } state_t;

  // Strict comparison under the min or max rule.
  function automatic logic better(input logic signed [31:0] a,
                                  input logic signed [31:0] b,
                                  input logic want_max);
    better = want_max ? (b < a) : (a < b);
  endfunction

endpackage
`default_nettype wire

>>> hdl/min_max_heap_priority_queue_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// min_max_heap_priority_queue_core: double-ended priority queue
// A min-max heap in one single-port memory, walked by a small sequencer.
// ---------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) carries one word of command
// and operand_value. Every accepted word gives exactly one result word on
// the output channel (out_valid/out_ready) with the removed value, status,
// current minimum and maximum, and the entry count.
// The block takes one word at a time: in_ready is high only while idle.
// All heap traffic goes through one memory port with registered read data.
// Insert into a non-empty heap reads the parent and compares with it, then
// each step of the bubble walk reads a grandparent and compares with it.
// A trickle step that moves a value down two levels does six reads, each
// followed by a compare, plus the resolve and the parent check. A final
// read of the root and its two children ends every command; peek, clear
// and an empty delete go to it directly. Reset clears the fill count; the
// memory itself is not cleared, since only entries below the fill count
// are ever used. A result waits in its output register while out_ready is
// low, and no new word is taken until it leaves.
// ---------------------------------------------------------------------------
module min_max_heap_priority_queue_core
  import mmh_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         command,
  input  wire logic signed [31:0] operand_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      removed_value,
  output logic [1:0]              status,
  output logic signed [31:0]      current_min,
  output logic signed [31:0]      current_max,
  output logic [10:0]             entry_count
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  // Indices may run past capacity while computing children.
  localparam int unsigned IW = CW + 3;

  state_t state, state_next;

  logic [CW-1:0] fill, fill_next;
  logic [IW-1:0] cur, cur_next;     // node being moved
  logic [IW-1:0] best, best_next;   // best candidate index
  logic [IW-1:0] probe, probe_next; // candidate being read
  logic [IW-1:0] other, other_next; // partner index (parent/grandparent)
  logic signed [31:0] cval, cval_next;  // value at cur
  logic signed [31:0] bval, bval_next;  // value at best
  logic signed [31:0] oval, oval_next;
  logic          mx, mx_next;           // max rule in force
  logic [2:0]    pcnt, pcnt_next;       // candidate number in a level
  logic signed [31:0] rem, rem_next;
  status_t       st, st_next;
  logic signed [31:0] mn, mn_next, mxv, mxv_next;

  logic          we;
  logic [IW-1:0] addr;
  logic signed [31:0] wdata, rdata;

  mmh_store #(.AW(AW)) u_store (
    .clk(clk), .we(we), .addr(addr[AW-1:0]), .wdata(wdata), .rdata(rdata)
  );

  // Depth parity of node i: floor(log2(i+1)) odd means a max level.
  function automatic logic max_level(input logic [IW-1:0] i);
    logic [IW:0] n;
    logic p;
    n = {1'b0, i} + 1'b1;
    p = 1'b0;
    for (int b = 0; b <= IW; b++) begin
      if (n[b]) p = b[0];
    end
    max_level = p;
  endfunction

  logic [IW-1:0] first_c;
  logic [IW-1:0] cand;
  logic [IW-1:0] fill_w;
  assign first_c = {cur[IW-2:0], 1'b1};
  assign fill_w  = IW'(fill);
  // candidates: 1 child, 2 child, then four grandchildren
  always_comb begin
    case (pcnt)
      3'd0:    cand = first_c;
      3'd1:    cand = first_c + 1'b1;
      3'd2:    cand = {first_c[IW-2:0], 1'b1};
      3'd3:    cand = {first_c[IW-2:0], 1'b1} + IW'(1);
      3'd4:    cand = {first_c[IW-2:0], 1'b1} + IW'(2);
      3'd5:    cand = {first_c[IW-2:0], 1'b1} + IW'(3);
      default: cand = '0;
    endcase
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
    end
    cur <= cur_next; best <= best_next; probe <= probe_next; other <= other_next;
    cval <= cval_next; bval <= bval_next; oval <= oval_next; mx <= mx_next;
    pcnt <= pcnt_next; rem <= rem_next; st <= st_next; mn <= mn_next;
    mxv <= mxv_next;
  end

  always_comb begin
    state_next = state; fill_next = fill; cur_next = cur; best_next = best;
    probe_next = probe; other_next = other; cval_next = cval; bval_next = bval;
    oval_next = oval; mx_next = mx; pcnt_next = pcnt; rem_next = rem;
    st_next = st; mn_next = mn; mxv_next = mxv;
    we = 1'b0; addr = cur; wdata = cval;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          rem_next = -32'sd1;
          st_next  = ST_OK;
          case (command)
            CMD_INSERT: begin
              if (fill_w >= IW'(CAPACITY)) begin
                st_next = ST_FULL; state_next = S_PK_R0;
              end else begin
                we = 1'b1; addr = fill_w; wdata = operand_value;
                cur_next = fill_w; cval_next = operand_value;
                fill_next = fill + 1'b1;
                state_next = (fill == '0) ? S_PK_R0 : S_INS_RP;
              end
            end
            CMD_DELMIN: begin
              if (fill == '0) begin
                st_next = ST_EMPTY; state_next = S_PK_R0;
              end else begin
                cur_next = '0; mx_next = 1'b0; addr = '0;
                state_next = S_DEL_PICK; pcnt_next = 3'd7;
              end
            end
            CMD_DELMAX: begin
              if (fill == '0) begin
                st_next = ST_EMPTY; state_next = S_PK_R0;
              end else if (fill == CW'(1)) begin
                addr = '0; cur_next = '0; pcnt_next = 3'd6;
                state_next = S_DEL_PICK;
              end else begin
                addr = IW'(1); mx_next = 1'b1; state_next = S_DEL_R1;
              end
            end
            CMD_CLEAR: begin
              fill_next = '0; state_next = S_PK_R0;
            end
            default: state_next = S_PK_R0;
          endcase
        end
      end
      S_INS_RP: begin
        other_next = (cur - 1'b1) >> 1;
        addr = (cur - 1'b1) >> 1;
        mx_next = max_level(cur);
        state_next = S_INS_CMP;
      end
      S_INS_CMP: begin
        if (better(rdata, cval, mx)) begin
          // swap with parent, then bubble the parent's rule from there
          we = 1'b1; addr = cur; wdata = rdata;
          cur_next = other; mx_next = ~mx;
        end
        state_next = S_BUB_RG;
      end
      S_BUB_RG: begin
        if (cur < IW'(3)) begin
          state_next = S_PK_R0;
        end else begin
          other_next = (((cur - 1'b1) >> 1) - 1'b1) >> 1;
          addr = (((cur - 1'b1) >> 1) - 1'b1) >> 1;
          state_next = S_BUB_CMP;
        end
      end
      S_BUB_CMP: begin
        if (better(cval, rdata, mx)) begin
          we = 1'b1; addr = cur; wdata = rdata; cur_next = other;
          state_next = S_BUB_RG;
        end else begin
          state_next = S_PK_R0;
        end
        // cval is written at its final place when the walk stops
      end
      S_DEL_R1: begin
        // node 1 is on rdata now; node 2 follows in the pick state
        oval_next = rdata; addr = IW'(2);
        state_next = S_DEL_PICK; pcnt_next = 3'd5;
      end
      S_DEL_PICK: begin
        // pcnt 7: delete min, root in rdata; 6: single entry; 5: max pick
        if (pcnt == 3'd5) begin
          if (fill > CW'(2) && oval < rdata) begin
            cur_next = IW'(2); rem_next = rdata;
          end else begin
            cur_next = IW'(1); rem_next = oval;
          end
        end else begin
          rem_next = rdata;
        end
        fill_next = fill - 1'b1;
        addr = IW'(fill - 1'b1);
        state_next = S_DEL_LAST;
      end
      S_DEL_LAST: begin
        if (cur < fill_w) begin
          cval_next = rdata;
          we = 1'b1; addr = cur; wdata = rdata;
          state_next = S_TR_START;
        end else begin
          state_next = S_PK_R0;
        end
      end
      S_TR_START: begin
        pcnt_next = '0;
        best_next = cur; bval_next = cval;
        if (first_c >= fill_w) state_next = S_PK_R0;
        else state_next = S_TR_RD;
      end
      S_TR_RD: begin
        if (pcnt == 3'd6 || cand >= fill_w) begin
          state_next = S_TR_RESOLVE;
        end else begin
          addr = cand; probe_next = cand; state_next = S_TR_CMP;
        end
      end
      S_TR_CMP: begin
        // first candidate always seeds best; later ones must beat it
        if (pcnt == '0 || better(rdata, bval, mx)) begin
          best_next = probe; bval_next = rdata;
        end
        pcnt_next = pcnt + 1'b1;
        state_next = S_TR_RD;
      end
      S_TR_RESOLVE: begin
        if (!better(bval, cval, mx)) begin
          state_next = S_PK_R0;
        end else begin
          we = 1'b1; addr = cur; wdata = bval;
          if (best <= first_c + 1'b1) begin
            addr = cur; wdata = bval;
            state_next = S_TR_RP; pcnt_next = 3'd7;
          end else begin
            state_next = S_TR_RP; pcnt_next = '0;
          end
        end
      end
      S_TR_RP: begin
        if (pcnt == 3'd7) begin
          // child swap ends the walk
          we = 1'b1; addr = best; wdata = cval;
          state_next = S_PK_R0;
        end else begin
          other_next = (best - 1'b1) >> 1;
          addr = (best - 1'b1) >> 1;
          state_next = S_TR_PCMP;
        end
      end
      S_TR_PCMP: begin
        if (better(rdata, cval, mx)) begin
          we = 1'b1; addr = other; wdata = cval;
          cval_next = rdata;
        end
        cur_next = best;
        state_next = S_TR_START;
        if (!better(rdata, cval, mx)) begin
          // cval stays; it is written at best on the next level or at the end
        end
      end
      S_PK_R0: begin
        addr = '0; state_next = S_PK_R1;
      end
      S_PK_R1: begin
        mn_next = rdata; addr = IW'(1); state_next = S_PK_R2;
      end
      S_PK_R2: begin
        mxv_next = rdata; addr = IW'(2); state_next = S_PK_END;
      end
      S_PK_END: begin
        if (fill == '0) begin
          mn_next = -32'sd1; mxv_next = -32'sd1;
        end else if (fill == CW'(1)) begin
          mxv_next = mn;
        end else if (fill > CW'(2) && mxv < rdata) begin
          mxv_next = rdata;
        end
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    // Pending value writes: in the bubble and trickle walks the moving
    // value lives in cval and is parked at cur before the final reads.
    if (state == S_BUB_RG && cur < IW'(3)) begin
      we = 1'b1; addr = cur; wdata = cval;
    end
    if (state == S_BUB_CMP && !better(cval, rdata, mx)) begin
      we = 1'b1; addr = cur; wdata = cval;
    end
    if (state == S_TR_START) begin
      we = 1'b1; addr = cur; wdata = cval;
    end
    if (state == S_TR_RESOLVE && !better(bval, cval, mx)) begin
      we = 1'b1; addr = cur; wdata = cval;
    end
  end

  assign out_valid     = (state == S_OUT);
  assign removed_value = rem;
  assign status        = st;
  assign current_min   = mn;
  assign current_max   = mxv;
  assign entry_count   = 11'(fill);

  ap_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("accepting while a result is pending");
  ap_fill_cap: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(CAPACITY)) else $error("fill count exceeds capacity");
  ap_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(fill))
    else $error("result lost while stalled");
  ap_empty_neg: assert property (@(posedge clk) disable iff (rst)
    out_valid && fill == '0 |-> mn == -32'sd1 && mxv == -32'sd1)
    else $error("empty heap reports values");

endmodule
`default_nettype wire

>>> hdl/mmh_store.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mmh_store: heap storage
// Single-port memory holding the heap words, registered read data.
// ---------------------------------------------------------------------------
module mmh_store #(
  parameter int unsigned AW = 10
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        addr,
  input  wire logic signed [31:0]   wdata,
  output logic signed [31:0]        rdata
);

  logic signed [31:0] mem [(1<<AW)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire
